### sv/sts_pkg.sv
// Shared types and constants for the S-expression token scanner.
package sts_pkg;

  // Token kinds as reported on the result channel
  typedef enum logic [2:0] {
    KIND_OPEN      = 3'd0,
    KIND_CLOSE     = 3'd1,
    KIND_NUMERIC   = 3'd2,
    KIND_LITERAL   = 3'd3,
    KIND_BAD_ATOM  = 3'd4,
    KIND_UNKNOWN   = 3'd5,
    KIND_LINE_DONE = 3'd6
  } kind_t;

  // Atom scan state
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  localparam logic [7:0]  CH_SPACE  = 8'd32;
  localparam logic [7:0]  CH_OPEN   = 8'd40;
  localparam logic [7:0]  CH_CLOSE  = 8'd41;
  localparam logic [7:0]  CH_ZERO   = 8'd48;
  localparam logic [7:0]  CH_NINE   = 8'd57;
  localparam logic [7:0]  CH_UPPER_A = 8'd65;
  localparam logic [7:0]  CH_UPPER_Z = 8'd90;
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // One result item
  typedef struct packed {
    kind_t              token_kind;
    logic [30:0]        atom_value;
    logic               value_overflow;
    logic [7:0]         atom_length;
    logic [31:0]        open_count;
    logic [31:0]        close_count;
    logic [31:0]        numeric_count;
    logic signed [31:0] numeric_total;
    logic [31:0]        literal_count;
    logic               last;
  } res_t;

  // Results caused by one input item
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } pair_t;

endpackage

### sv/sts_if.sv
// Handshake interfaces for the scanner's input and result channels.
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source(output valid, char_code, line_end, input ready);
  modport sink(input valid, char_code, line_end, output ready);
endinterface

interface sts_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic [30:0]        atom_value;
  logic               value_overflow;
  logic [7:0]         atom_length;
  logic [31:0]        open_count;
  logic [31:0]        close_count;
  logic [31:0]        numeric_count;
  logic signed [31:0] numeric_total;
  logic [31:0]        literal_count;
  logic               last;

  modport source(output valid, token_kind, atom_value, value_overflow, atom_length,
                 open_count, close_count, numeric_count, numeric_total,
                 literal_count, last, input ready);
  modport sink(input valid, token_kind, atom_value, value_overflow, atom_length,
               open_count, close_count, numeric_count, numeric_total,
               literal_count, last, output ready);
endinterface

### sv/sts_scan.sv
// Scanner state and per-character token logic; builds the results of one item.
module sts_scan #(
  parameter int COUNT_WIDTH  = 32,
  parameter int LENGTH_WIDTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_code,
  input  logic          line_end,
  output sts_pkg::pair_t pair
);

  typedef logic [COUNT_WIDTH-1:0]  cnt_t;
  typedef logic [LENGTH_WIDTH-1:0] len_t;

  sts_pkg::mode_t mode, mode_next;
  logic [30:0]    val, val_next;
  logic           ovf, ovf_next;
  len_t           len, len_next;
  logic           halted, halted_next;
  cnt_t           ot, ot_next, ct, ct_next, nt, nt_next, lt, lt_next;
  logic [31:0]    ns, ns_next;

  function automatic cnt_t bump(input cnt_t x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic logic [31:0] cnt32(input cnt_t x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  function automatic logic [7:0] len8(input len_t x);
    logic [15:0] w;
    w = 16'(x);
    return w[7:0];
  endfunction

  function automatic sts_pkg::res_t make_res(input sts_pkg::kind_t k, input logic [30:0] v,
                                             input logic o, input len_t l, input cnt_t a,
                                             input cnt_t b, input cnt_t n, input logic [31:0] s,
                                             input cnt_t t);
    sts_pkg::res_t r;
    r.token_kind     = k;
    r.atom_value     = v;
    r.value_overflow = o;
    r.atom_length    = len8(l);
    r.open_count     = cnt32(a);
    r.close_count    = cnt32(b);
    r.numeric_count  = cnt32(n);
    r.numeric_total  = s;
    r.literal_count  = cnt32(t);
    r.last           = 1'b0;
    return r;
  endfunction

  logic          digit, upper, stop;
  logic [3:0]    dig;
  logic [34:0]   v10;
  logic [1:0]    ne;
  sts_pkg::res_t res [2];

  assign digit = (char_code >= sts_pkg::CH_ZERO) && (char_code <= sts_pkg::CH_NINE);
  assign upper = (char_code >= sts_pkg::CH_UPPER_A) && (char_code <= sts_pkg::CH_UPPER_Z);
  assign dig   = 4'(char_code - sts_pkg::CH_ZERO);
  // value * 10 + digit as two shifts and adds
  assign v10   = 35'({val, 3'b000}) + 35'({val, 1'b0}) + 35'(dig);

  // Next state and emitted results
  always_comb begin
    mode_next   = mode;
    val_next    = val;
    ovf_next    = ovf;
    len_next    = len;
    halted_next = halted;
    ot_next     = ot;
    ct_next     = ct;
    nt_next     = nt;
    ns_next     = ns;
    lt_next     = lt;
    stop        = 1'b0;
    ne          = 2'd0;
    res[0]      = '0;
    res[1]      = '0;
    if (accept && !halted) begin
      if (!line_end && (mode != sts_pkg::MODE_IDLE) && (digit || upper)) begin
        // extend the pending atom
        if (len != '1) len_next = len + 1'b1;
        if (mode == sts_pkg::MODE_NUM && upper) begin
          mode_next = sts_pkg::MODE_BAD;
        end else if (mode == sts_pkg::MODE_NUM) begin
          if (v10 > 35'(sts_pkg::VALUE_MAX)) begin
            val_next = sts_pkg::VALUE_MAX;
            ovf_next = 1'b1;
          end else begin
            val_next = v10[30:0];
          end
        end
      end else begin
        // flush any pending atom
        mode_next = sts_pkg::MODE_IDLE;
        case (mode)
          sts_pkg::MODE_NUM: begin
            nt_next = bump(nt);
            ns_next = ns + 32'(val);
            res[ne[0]] = make_res(sts_pkg::KIND_NUMERIC, val, ovf, len,
                                  ot_next, ct_next, nt_next, ns_next, lt_next);
            ne = ne + 2'd1;
          end
          sts_pkg::MODE_LIT: begin
            lt_next = bump(lt);
            res[ne[0]] = make_res(sts_pkg::KIND_LITERAL, '0, 1'b0, len,
                                  ot_next, ct_next, nt_next, ns_next, lt_next);
            ne = ne + 2'd1;
          end
          sts_pkg::MODE_BAD: begin
            res[ne[0]] = make_res(sts_pkg::KIND_BAD_ATOM, '0, 1'b0, len,
                                  ot_next, ct_next, nt_next, ns_next, lt_next);
            ne = ne + 2'd1;
            halted_next = 1'b1;
            stop = 1'b1;
          end
          default: ;
        endcase
        // then the current character or line end
        if (!stop) begin
          if (line_end) begin
            res[ne[0]] = make_res(sts_pkg::KIND_LINE_DONE, '0, 1'b0, '0,
                                  ot_next, ct_next, nt_next, ns_next, lt_next);
            ne = ne + 2'd1;
          end else begin
            case (char_code)
              sts_pkg::CH_SPACE: ;
              sts_pkg::CH_OPEN: begin
                ot_next = bump(ot);
                res[ne[0]] = make_res(sts_pkg::KIND_OPEN, '0, 1'b0, '0,
                                      ot_next, ct_next, nt_next, ns_next, lt_next);
                ne = ne + 2'd1;
              end
              sts_pkg::CH_CLOSE: begin
                ct_next = bump(ct);
                res[ne[0]] = make_res(sts_pkg::KIND_CLOSE, '0, 1'b0, '0,
                                      ot_next, ct_next, nt_next, ns_next, lt_next);
                ne = ne + 2'd1;
              end
              default: begin
                if (digit || upper) begin
                  mode_next = upper ? sts_pkg::MODE_LIT : sts_pkg::MODE_NUM;
                  val_next  = upper ? 31'd0 : 31'(dig);
                  ovf_next  = 1'b0;
                  len_next  = len_t'(1);
                end else begin
                  res[ne[0]] = make_res(sts_pkg::KIND_UNKNOWN, '0, 1'b0, '0,
                                        ot_next, ct_next, nt_next, ns_next, lt_next);
                  ne = ne + 2'd1;
                  halted_next = 1'b1;
                end
              end
            endcase
          end
        end
      end
    end
    // mark the final result of this item
    if (ne == 2'd1) res[0].last = 1'b1;
    if (ne == 2'd2) res[1].last = 1'b1;
    pair.count  = ne;
    pair.first  = res[0];
    pair.second = res[1];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= sts_pkg::MODE_IDLE;
      val    <= '0;
      ovf    <= 1'b0;
      len    <= '0;
      halted <= 1'b0;
      ot     <= '0;
      ct     <= '0;
      nt     <= '0;
      ns     <= '0;
      lt     <= '0;
    end else begin
      mode   <= mode_next;
      val    <= val_next;
      ovf    <= ovf_next;
      len    <= len_next;
      halted <= halted_next;
      ot     <= ot_next;
      ct     <= ct_next;
      nt     <= nt_next;
      ns     <= ns_next;
      lt     <= lt_next;
    end
  end

endmodule

### sv/sts_out.sv
// Two-entry result register that drains one result item per cycle while dout.ready is high.
module sts_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  sts_pkg::pair_t pair,
  output logic           can_load,
  sts_out_if.source      dout
);

  logic          a_valid, b_valid;
  sts_pkg::res_t a, b;
  logic          fire;

  assign fire     = a_valid && dout.ready;
  // room for a full pair once the head leaves and nothing waits behind it
  assign can_load = !b_valid && (!a_valid || dout.ready);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (load && pair.count != 2'd0) begin
      a_valid <= 1'b1;
      b_valid <= (pair.count == 2'd2);
    end else if (fire) begin
      if (b_valid) b_valid <= 1'b0;
      else a_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && pair.count != 2'd0) begin
      a <= pair.first;
      b <= pair.second;
    end else if (fire && b_valid) begin
      a <= b;
    end
  end

  assign dout.valid          = a_valid;
  assign dout.token_kind     = a.token_kind;
  assign dout.atom_value     = a.atom_value;
  assign dout.value_overflow = a.value_overflow;
  assign dout.atom_length    = a.atom_length;
  assign dout.open_count     = a.open_count;
  assign dout.close_count    = a.close_count;
  assign dout.numeric_count  = a.numeric_count;
  assign dout.numeric_total  = a.numeric_total;
  assign dout.literal_count  = a.literal_count;
  assign dout.last           = a.last;

endmodule

### sv/sexpr_token_scanner_top.sv
// S-expression token scanner: one character item in, up to two token result items out.
// The first result of an item is shown the cycle after the item is accepted.
// Throughput: one item per cycle while dout.ready is high; an item with two results holds
// the input until the single result port has drained its first result from the two-entry result register.
// Reset (rst, synchronous): scan state, halt flag and all tallies clear to zero,
// result register empties.
module sexpr_token_scanner_top #(
  parameter int COUNT_WIDTH  = 32,
  parameter int LENGTH_WIDTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  sts_in_if.sink  din,
  sts_out_if.source dout
);

  logic           accept, can_load;
  sts_pkg::pair_t pair;

  assign din.ready = can_load;
  assign accept    = din.valid && can_load;

  sts_scan #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (din.char_code),
    .line_end  (din.line_end),
    .pair      (pair)
  );

  sts_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .pair     (pair),
    .can_load (can_load),
    .dout     (dout)
  );

endmodule

### sv/sts_checker.sv
// Port-level checks for the token scanner, bound to the top level.
module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  token_kind,
  input logic [30:0] atom_value,
  input logic        value_overflow,
  input logic        last
);

  // a waiting result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // an error token ends the results of its item
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == sts_pkg::KIND_BAD_ATOM ||
                  token_kind == sts_pkg::KIND_UNKNOWN) |-> last)
    else $error("error token not final");

  // line done is always the final result of its item
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == sts_pkg::KIND_LINE_DONE |-> last)
    else $error("line done not final");

  // only numeric atoms carry a value or overflow flag
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != sts_pkg::KIND_NUMERIC |->
      atom_value == 31'd0 && !value_overflow)
    else $error("value on non-numeric token");

endmodule

bind sexpr_token_scanner_top sts_checker u_sts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .token_kind     (dout.token_kind),
  .atom_value     (dout.atom_value),
  .value_overflow (dout.value_overflow),
  .last           (dout.last)
);
